// File: design/euler_xyz_vector_rotation_assert.svh
// Assertion macros used by the Euler rotation top level.
`ifndef EULER_XYZ_VECTOR_ROTATION_ASSERT_SVH
`define EULER_XYZ_VECTOR_ROTATION_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EULROT_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EULROT_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

// File: design/eulrot_pkg.sv
// Types, constants and the multiply and round-and-saturate functions of the Euler rotation.
package eulrot_pkg;

	localparam int COORD_WIDTH    = 32;
	localparam int COEF_FRAC_BITS = 14;
	localparam int COEF_BITS      = 16;
	localparam int NUM_REGS       = 6;

	localparam int PROD_W = COORD_WIDTH + COEF_BITS;
	localparam int SUM_W  = PROD_W + 2;
	localparam int RND_W  = SUM_W - COEF_FRAC_BITS;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]      prod_t;

	localparam coef_t COEF_ONE  = COEF_BITS'(64'(1) << COEF_FRAC_BITS);
	localparam coef_t COEF_ZERO = '0;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'(1) << (COEF_FRAC_BITS - 1));

	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_COS_ALPHA = 3'd0,
		REG_SIN_ALPHA = 3'd1,
		REG_COS_BETA  = 3'd2,
		REG_SIN_BETA  = 3'd3,
		REG_COS_GAMMA = 3'd4,
		REG_SIN_GAMMA = 3'd5
	} reg_idx_t;

	// Full product of a coefficient and a coordinate.
	function automatic prod_t mul(coef_t c, coord_t d);
		prod_t pc;
		prod_t pd;
		pc = PROD_W'(c);
		pd = PROD_W'(d);
		return pc * pd;
	endfunction

	// Sum or difference of two products, rounded half up and saturated.
	function automatic coord_t rnd_sat(prod_t a, prod_t b, logic sub);
		logic signed [SUM_W-1:0] sa;
		logic signed [SUM_W-1:0] sb;
		logic signed [SUM_W-1:0] s;
		logic signed [RND_W-1:0] r;
		coord_t res;
		sa = SUM_W'(a);
		sb = SUM_W'(b);
		s = sub ? (sa - sb + ROUND_HALF) : (sa + sb + ROUND_HALF);
		r = s[SUM_W-1:COEF_FRAC_BITS];
		if (&r[RND_W-1:COORD_WIDTH-1] || ~|r[RND_W-1:COORD_WIDTH-1]) begin
			res = r[COORD_WIDTH-1:0];
		end else if (r[RND_W-1]) begin
			res = COORD_MIN;
		end else begin
			res = COORD_MAX;
		end
		return res;
	endfunction

endpackage

// File: design/euler_xyz_vector_rotation.sv
// Top level of the Euler XYZ vector rotation pipeline.
// Rotates a stream of signed Q16.16 vectors by alpha about x, beta about y and gamma
// about z, with the six cosines and sines held in APB registers in signed Q2.14
// (index 0 to 5: cos/sin alpha, cos/sin beta, cos/sin gamma, at byte addresses 0 to 20;
// reset to the identity rotation). Each rotation rounds half up and saturates to
// 32 bits before the next one uses it. The block takes one vector per clock cycle
// while the output does not stall: every rotation is split into a multiply stage and an
// add, round and saturate stage, and the six stages have per-stage flow control so
// that bubbles close up while the output waits. The last flag travels with its vector.
// The registers must only be written while no vector is in the pipeline.
module euler_xyz_vector_rotation (
	input  logic         clk,
	input  logic         arst_n,
	// Input vectors
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // in_x [31:0], in_y [63:32], in_z [95:64]
	input  logic         s_tlast,   // last_in
	// Rotated vectors
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
	output logic         m_tlast,   // last_out
	// Configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	`include "euler_xyz_vector_rotation_assert.svh"

	localparam int CW = eulrot_pkg::COORD_WIDTH;
	localparam int CB = eulrot_pkg::COEF_BITS;

	// Coefficient registers.
	eulrot_pkg::coef_t cos_a_q, sin_a_q, cos_b_q, sin_b_q, cos_g_q, sin_g_q;
	eulrot_pkg::reg_idx_t reg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = eulrot_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_a_q <= eulrot_pkg::COEF_ONE;
			sin_a_q <= eulrot_pkg::COEF_ZERO;
			cos_b_q <= eulrot_pkg::COEF_ONE;
			sin_b_q <= eulrot_pkg::COEF_ZERO;
			cos_g_q <= eulrot_pkg::COEF_ONE;
			sin_g_q <= eulrot_pkg::COEF_ZERO;
		end else if (cfg_wr) begin
			// Addresses beyond the sixth register are ignored.
			case (reg_idx)
				eulrot_pkg::REG_COS_ALPHA: cos_a_q <= pwdata[CB-1:0];
				eulrot_pkg::REG_SIN_ALPHA: sin_a_q <= pwdata[CB-1:0];
				eulrot_pkg::REG_COS_BETA:  cos_b_q <= pwdata[CB-1:0];
				eulrot_pkg::REG_SIN_BETA:  sin_b_q <= pwdata[CB-1:0];
				eulrot_pkg::REG_COS_GAMMA: cos_g_q <= pwdata[CB-1:0];
				eulrot_pkg::REG_SIN_GAMMA: sin_g_q <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			eulrot_pkg::REG_COS_ALPHA: prdata = {{(32-CB){1'b0}}, cos_a_q};
			eulrot_pkg::REG_SIN_ALPHA: prdata = {{(32-CB){1'b0}}, sin_a_q};
			eulrot_pkg::REG_COS_BETA:  prdata = {{(32-CB){1'b0}}, cos_b_q};
			eulrot_pkg::REG_SIN_BETA:  prdata = {{(32-CB){1'b0}}, sin_b_q};
			eulrot_pkg::REG_COS_GAMMA: prdata = {{(32-CB){1'b0}}, cos_g_q};
			eulrot_pkg::REG_SIN_GAMMA: prdata = {{(32-CB){1'b0}}, sin_g_q};
			default:                   prdata = '0;
		endcase
	end

	// Per-stage flow control: a stage loads when it is empty or its contents move on
	// in the same cycle, so a stalled output only holds back the stages behind it
	// once every bubble in between has been filled.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6 = !vld_s6 || m_tready;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= s_tvalid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	eulrot_pkg::coord_t in_x, in_y, in_z;
	assign in_x = s_tdata[CW-1:0];
	assign in_y = s_tdata[2*CW-1:CW];
	assign in_z = s_tdata[3*CW-1:2*CW];

	// Stage 1: alpha products.
	eulrot_pkg::prod_t  cy_s1, sz_s1, sy_s1, cz_s1;
	eulrot_pkg::coord_t x_s1;
	logic               last_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			cy_s1   <= eulrot_pkg::mul(cos_a_q, in_y);
			sz_s1   <= eulrot_pkg::mul(sin_a_q, in_z);
			sy_s1   <= eulrot_pkg::mul(sin_a_q, in_y);
			cz_s1   <= eulrot_pkg::mul(cos_a_q, in_z);
			x_s1    <= in_x;
			last_s1 <= s_tlast;
		end
	end

	// Stage 2: y and z after the rotation about x.
	eulrot_pkg::coord_t x_s2, y_s2, z_s2;
	logic               last_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			y_s2    <= eulrot_pkg::rnd_sat(cy_s1, sz_s1, 1'b1);
			z_s2    <= eulrot_pkg::rnd_sat(cz_s1, sy_s1, 1'b0);
			x_s2    <= x_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: beta products.
	eulrot_pkg::prod_t  cx_s3, sz_s3, sx_s3, cz_s3;
	eulrot_pkg::coord_t y_s3;
	logic               last_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			cx_s3   <= eulrot_pkg::mul(cos_b_q, x_s2);
			sz_s3   <= eulrot_pkg::mul(sin_b_q, z_s2);
			sx_s3   <= eulrot_pkg::mul(sin_b_q, x_s2);
			cz_s3   <= eulrot_pkg::mul(cos_b_q, z_s2);
			y_s3    <= y_s2;
			last_s3 <= last_s2;
		end
	end

	// Stage 4: x and z after the rotation about y.
	eulrot_pkg::coord_t x_s4, y_s4, z_s4;
	logic               last_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			x_s4    <= eulrot_pkg::rnd_sat(cx_s3, sz_s3, 1'b0);
			z_s4    <= eulrot_pkg::rnd_sat(cz_s3, sx_s3, 1'b1);
			y_s4    <= y_s3;
			last_s4 <= last_s3;
		end
	end

	// Stage 5: gamma products.
	eulrot_pkg::prod_t  cx_s5, sy_s5, sx_s5, cy_s5;
	eulrot_pkg::coord_t z_s5;
	logic               last_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			cx_s5   <= eulrot_pkg::mul(cos_g_q, x_s4);
			sy_s5   <= eulrot_pkg::mul(sin_g_q, y_s4);
			sx_s5   <= eulrot_pkg::mul(sin_g_q, x_s4);
			cy_s5   <= eulrot_pkg::mul(cos_g_q, y_s4);
			z_s5    <= z_s4;
			last_s5 <= last_s4;
		end
	end

	// Stage 6: x and y after the rotation about z; this is the output register.
	eulrot_pkg::coord_t x_s6, y_s6, z_s6;
	logic               last_s6;

	always_ff @(posedge clk) begin
		if (adv6) begin
			x_s6    <= eulrot_pkg::rnd_sat(cx_s5, sy_s5, 1'b1);
			y_s6    <= eulrot_pkg::rnd_sat(cy_s5, sx_s5, 1'b0);
			z_s6    <= z_s5;
			last_s6 <= last_s5;
		end
	end

	assign m_tvalid = vld_s6;
	assign m_tdata  = {z_s6, y_s6, x_s6};
	assign m_tlast  = last_s6;

	// Input back-pressure only ever appears with every stage occupied.
	`EULROT_ASSERT_NOW(a_full_when_blocked, !s_tready,
		vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6,
		"input stalled while the pipeline has a bubble")
	// A vector that leaves stage five always lands in the output register.
	`EULROT_ASSERT_NEXT(a_handoff_out, vld_s5 && adv6, m_tvalid,
		"vector lost between the gamma product and output stages")
	// An accepted vector always occupies the first stage next cycle.
	`EULROT_ASSERT_NEXT(a_handoff_in, s_tvalid && s_tready, vld_s1,
		"accepted vector not captured by the first stage")

endmodule
